>>> design/jse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared payload types, run classification codes and escape helpers.
// ----------------------------------------------------------------------------
package jse_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W      = 3;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	// Position of each byte within a run.
	localparam logic [IDX_W-1:0] POS_FIRST  = 3'd0;
	localparam logic [IDX_W-1:0] POS_SECOND = 3'd1;
	localparam logic [IDX_W-1:0] POS_ZERO_A = 3'd2;
	localparam logic [IDX_W-1:0] POS_ZERO_B = 3'd3;
	localparam logic [IDX_W-1:0] POS_HEX_HI = 3'd4;
	localparam logic [IDX_W-1:0] POS_HEX_LO = 3'd5;

	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_SHORT,
		KIND_UNICODE
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} out_item_t;

	// One classified input byte. For a short escape, data holds the letter.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       eos;
	} class_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h57 + {4'd0, nib};
		end
		return c;
	endfunction

endpackage : jse_pkg
`default_nettype wire

>>> design/jse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON escaper front end
// Classifies each accepted byte as plain, short escape or unicode escape.
// ----------------------------------------------------------------------------
module jse_front
	import jse_pkg::*;
(
	input  var in_item_t item,
	output var class_t   cls
);

	always_comb begin
		cls.eos  = item.end_of_string;
		cls.kind = KIND_SHORT;
		cls.data = item.in_byte;
		case (item.in_byte) inside
			CH_QUOTE, CH_BSLASH: begin
				cls.data = item.in_byte;
			end
			8'h08: begin
				cls.data = 8'h62;
			end
			8'h0C: begin
				cls.data = 8'h66;
			end
			8'h0A: begin
				cls.data = 8'h6E;
			end
			8'h0D: begin
				cls.data = 8'h72;
			end
			8'h09: begin
				cls.data = 8'h74;
			end
			[8'h00:8'h1F], CH_DEL: begin
				cls.kind = KIND_UNICODE;
			end
			default: begin
				cls.kind = KIND_PLAIN;
			end
		endcase
	end

endmodule : jse_front
`default_nettype wire

>>> design/jse_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON escaper classification queue
// Short register queue that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module jse_fifo
	import jse_pkg::*;
(
	input  var logic   clk,
	input  var logic   arst_n,
	input  var logic   wr_en,
	input  var class_t wr_data,
	output var logic   full,
	input  var logic   rd_en,
	output var class_t rd_data,
	output var logic   rd_valid
);

	class_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("queue count exceeds depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("queue read while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("queue written while full");

endmodule : jse_fifo
`default_nettype wire

>>> design/jse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON escaper serializer
// Expands each classified byte into its run and holds it in the result register.
// ----------------------------------------------------------------------------
module jse_back
	import jse_pkg::*;
(
	input  var logic      clk,
	input  var logic      arst_n,
	input  var class_t    head,
	input  var logic      head_valid,
	output var logic      head_pop,
	output var out_item_t result,
	output var logic      empty,
	input  var logic      pop
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             load;
	logic [7:0]       sel_byte;
	logic             sel_last;

	always_comb begin
		sel_byte = CH_BSLASH;
		sel_last = 1'b0;
		case (head.kind)
			KIND_PLAIN: begin
				sel_byte = head.data;
				sel_last = 1'b1;
			end
			KIND_SHORT: begin
				if (idx_q != POS_FIRST) begin
					sel_byte = head.data;
					sel_last = 1'b1;
				end
			end
			KIND_UNICODE: begin
				case (idx_q)
					POS_FIRST:  sel_byte = CH_BSLASH;
					POS_SECOND: sel_byte = CH_U;
					POS_ZERO_A: sel_byte = CH_ZERO;
					POS_ZERO_B: sel_byte = CH_ZERO;
					POS_HEX_HI: sel_byte = hex_char(head.data[7:4]);
					default: begin
						sel_byte = hex_char(head.data[3:0]);
						sel_last = 1'b1;
					end
				endcase
			end
			default: begin
				sel_byte = head.data;
				sel_last = 1'b1;
			end
		endcase
	end

	// The result register refills in the same cycle its byte is transferred.
	assign load     = head_valid && (!out_valid_q || pop);
	assign head_pop = load && sel_last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= sel_byte;
			out_q.run_last    <= sel_last;
			out_q.string_last <= sel_last && head.eos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= POS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= sel_last ? POS_FIRST : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= POS_HEX_LO)
		else $error("run position out of range");

	a_run_holds_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != POS_FIRST) |-> head_valid)
		else $error("run in progress without a queued byte");

	a_string_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.string_last) |-> out_q.run_last)
		else $error("string end flagged inside a run");

endmodule : jse_back
`default_nettype wire

>>> design/json_string_escaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON string escaper
// Takes one string byte per transfer and returns its JSON-escaped run.
// ----------------------------------------------------------------------------
// A run's first byte reaches the result ports via the queue and then the
// result register. The single result register sends one byte per cycle
// while pop is held and a byte is queued; plain bytes enter one per cycle
// while not full, and the four-entry queue absorbs two- or six-byte escape
// runs. Reset clears the queue, the result register and the run position.
// ----------------------------------------------------------------------------
module json_string_escaper
	import jse_pkg::*;
(
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      push,
	output var logic      full,
	input  var in_item_t  item,
	output var logic      empty,
	input  var logic      pop,
	output var out_item_t result
);

	class_t cls;
	class_t head;
	logic   head_valid;
	logic   head_pop;

	jse_front u_front (
		.item (item),
		.cls  (cls)
	);

	jse_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push && !full),
		.wr_data  (cls),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.rd_valid (head_valid)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule : json_string_escaper
`default_nettype wire
